/* sv/lbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types and constants of the linear blend skinning block.
// ----------------------------------------------------------------------------
package lbs_pkg;

    localparam int DEF_MAX_JOINTS = 64;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int WEIGHT_FRAC    = 15;
    localparam int MAT_ELEMS      = 12;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_W    = 2;

    // what the back end has to do with a queued word
    typedef enum logic [1:0] {
        K_LOAD,
        K_MIX,
        K_FLUSH
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [5:0]         joint;
        logic [3:0]         element;
        logic signed [31:0] value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        weight;
        logic               last;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qword;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_DRAIN,
        B_EMIT
    } t_bstate;

endpackage

/* sv/linear_blend_skinning.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_blend_skinning
// Fixed-point linear blend skinning engine with a matrix store per joint.
// ----------------------------------------------------------------------------
// Words enter a four-deep queue at up to one per cycle while it is not full;
// loads with a bad joint or element, and contributions with an unknown joint
// that do not close a vertex, are dropped there. The back end writes a matrix
// load to the RAM in the cycle it takes the word; a joint contribution runs
// through the take, twelve reads through the one read port of the matrix RAM
// feeding one 32x32 multiplier, then a drain into the accumulators. Closing a
// vertex adds an emit step once the output register is free; a closing word
// with an unknown joint goes to that emit step directly. The deformed position
// is held in an output register until popped; the queue keeps taking words
// meanwhile. Matrices must be loaded before they are used.
// ----------------------------------------------------------------------------
module linear_blend_skinning import lbs_pkg::*; #(
    parameter int MAX_JOINTS = DEF_MAX_JOINTS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_command,
    input  logic [5:0]         i_joint,
    input  logic [3:0]         i_element,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [15:0]        i_weight,
    input  logic               i_last,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z
);

    t_qword head;
    logic   take;

    lbs_front #(
        .MAX_JOINTS (MAX_JOINTS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_command (i_command),
        .i_joint   (i_joint),
        .i_element (i_element),
        .i_value   (i_value),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_pos_z   (i_pos_z),
        .i_weight  (i_weight),
        .i_last    (i_last),
        .o_head    (head),
        .i_take    (take)
    );

    lbs_back #(
        .MAX_JOINTS (MAX_JOINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_take  (take),
        .o_empty (empty),
        .i_pop   (pop),
        .o_out_x (o_out_x),
        .o_out_y (o_out_y),
        .o_out_z (o_out_z)
    );

endmodule

/* sv/lbs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/lbs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_front
// Input side: checks each word, drops the ones with no effect and queues the
// rest for the back end.
// ----------------------------------------------------------------------------
module lbs_front import lbs_pkg::*; #(
    parameter int MAX_JOINTS = DEF_MAX_JOINTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic               i_command,
    input  logic [5:0]         i_joint,
    input  logic [3:0]         i_element,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [15:0]        i_weight,
    input  logic               i_last,
    output t_qword             o_head,
    input  logic               i_take
);

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;
    logic [QUEUE_PTR_W-1:0] n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] n_rd_ptr;
    logic [QUEUE_PTR_W:0]   n_count;

    logic  joint_ok;
    logic  keep;
    logic  push_en;
    logic  pop_en;
    t_item new_item;

    assign joint_ok = {26'd0, i_joint} < 32'(MAX_JOINTS);

    always_comb begin
        new_item.joint   = i_joint;
        new_item.element = i_element;
        new_item.value   = i_value;
        new_item.pos_x   = i_pos_x;
        new_item.pos_y   = i_pos_y;
        new_item.pos_z   = i_pos_z;
        new_item.weight  = i_weight;
        new_item.last    = i_last;
        new_item.kind    = K_LOAD;
        keep             = 1'b0;
        if (!i_command) begin
            new_item.kind = K_LOAD;
            keep          = joint_ok && (i_element < 4'(MAT_ELEMS));
        end else if (joint_ok) begin
            new_item.kind = K_MIX;
            keep          = 1'b1;
        end else begin
            // unknown joint still closes the vertex
            new_item.kind = K_FLUSH;
            keep          = i_last;
        end
    end

    assign o_full  = (r_count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign push_en = i_push && !o_full && keep;
    assign pop_en  = i_take && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push_en ? r_wr_ptr + QUEUE_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = pop_en ? r_rd_ptr + QUEUE_PTR_W'(1) : r_rd_ptr;
        unique case ({push_en, pop_en})
            2'b10:   n_count = r_count + (QUEUE_PTR_W + 1)'(1);
            2'b01:   n_count = r_count - (QUEUE_PTR_W + 1)'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wr_ptr] <= new_item;
        end
    end

endmodule

/* sv/lbs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_back
// Execution side: matrix store, per-element multiply pipeline, accumulators
// and the result register.
// ----------------------------------------------------------------------------
module lbs_back import lbs_pkg::*; #(
    parameter int MAX_JOINTS = DEF_MAX_JOINTS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_qword             i_head,
    output logic               o_take,
    output logic               o_empty,
    input  logic               i_pop,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z
);

    localparam int DEPTH = MAX_JOINTS * MAT_ELEMS;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic signed [31:0] sat_to32(input logic signed [65:0] a);
        logic signed [31:0] res;
        if ((&a[65:31]) || !(|a[65:31])) begin
            res = a[31:0];
        end else if (a[65]) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'sh7fff_ffff;
        end
        return res;
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] res;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            res = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            res = s[63:0];
        end
        return res;
    endfunction

    t_bstate r_state;
    t_bstate n_state;

    logic          issue;
    logic          emit_go;
    logic          ram_we;
    logic          pipe_busy;
    logic [13:0]   head_base;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic [AW-1:0]      r_base;
    logic [3:0]         r_cnt;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [31:0] r_pz;
    logic [15:0]        r_weight;
    logic               r_last;

    // pipeline: read, multiply, row sum, row scale, weight, accumulate
    logic               r_v0, r_v1, r_v2, r_v3, r_v4;
    logic [1:0]         r_col0, r_col1;
    logic [1:0]         r_row0, r_row1, r_row2, r_row3, r_row4;
    logic signed [63:0] r_prod;
    logic signed [65:0] r_sum;
    logic signed [31:0] r_rowval;
    logic signed [48:0] r_wprod;
    logic signed [63:0] r_acc [3];

    logic signed [31:0] rd_s;
    logic signed [31:0] mul_op;
    logic signed [63:0] prod;

    logic               r_out_valid;
    logic signed [31:0] r_out_x;
    logic signed [31:0] r_out_y;
    logic signed [31:0] r_out_z;

    assign head_base = 14'(i_head.item.joint) * 14'(MAT_ELEMS);
    assign ram_waddr = AW'(head_base + 14'(i_head.item.element));
    assign ram_raddr = r_base + AW'(r_cnt);
    assign pipe_busy = r_v0 || r_v1 || r_v2 || r_v3 || r_v4;

    lbs_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_head.item.value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_head.valid) begin
                    unique case (i_head.item.kind)
                        K_MIX:   n_state = B_RUN;
                        K_FLUSH: n_state = B_EMIT;
                        default: n_state = B_IDLE;
                    endcase
                end
            end
            B_RUN: begin
                if (r_cnt == 4'(MAT_ELEMS - 1)) begin
                    n_state = B_DRAIN;
                end
            end
            B_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = r_last ? B_EMIT : B_IDLE;
                end
            end
            B_EMIT: begin
                if (!r_out_valid || i_pop) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_take  = 1'b0;
        ram_we  = 1'b0;
        issue   = 1'b0;
        emit_go = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                o_take = i_head.valid;
                ram_we = i_head.valid && (i_head.item.kind == K_LOAD);
            end
            B_RUN:   issue   = 1'b1;
            B_DRAIN: issue   = 1'b0;
            B_EMIT:  emit_go = !r_out_valid || i_pop;
            default: issue   = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_cnt   <= '0;
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_take) begin
                r_cnt <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + 4'd1;
            end
            r_v0 <= issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1 && (r_col1 == 2'd3);
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_base   <= AW'(head_base);
            r_px     <= i_head.item.pos_x;
            r_py     <= i_head.item.pos_y;
            r_pz     <= i_head.item.pos_z;
            r_weight <= i_head.item.weight;
            r_last   <= i_head.item.last;
        end
    end

    assign rd_s = signed'(ram_rdata);

    always_comb begin
        unique case (r_col0)
            2'd0:    mul_op = r_px;
            2'd1:    mul_op = r_py;
            2'd2:    mul_op = r_pz;
            default: mul_op = '0;
        endcase
        // translation column is scaled by one, i.e. a shift
        if (r_col0 == 2'd3) begin
            prod = 64'(rd_s) <<< FRAC_BITS;
        end else begin
            prod = 64'(rd_s) * 64'(mul_op);
        end
    end

    always_ff @(posedge i_clk) begin
        r_col0 <= r_cnt[1:0];
        r_row0 <= r_cnt[3:2];
        r_col1 <= r_col0;
        r_row1 <= r_row0;
        r_row2 <= r_row1;
        r_row3 <= r_row2;
        r_row4 <= r_row3;
        r_prod <= prod;
        if (r_v1) begin
            r_sum <= (r_col1 == 2'd0) ? 66'(r_prod) : r_sum + 66'(r_prod);
        end
        r_rowval <= sat_to32(r_sum >>> FRAC_BITS);
        r_wprod  <= 49'(r_rowval) * 49'(signed'({1'b0, r_weight}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc[0] <= '0;
            r_acc[1] <= '0;
            r_acc[2] <= '0;
        end else if (emit_go) begin
            r_acc[0] <= '0;
            r_acc[1] <= '0;
            r_acc[2] <= '0;
        end else if (r_v4) begin
            r_acc[r_row4] <= sat_add64(r_acc[r_row4], 64'(r_wprod));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out_x <= sat_to32(66'(r_acc[0] >>> WEIGHT_FRAC));
            r_out_y <= sat_to32(66'(r_acc[1] >>> WEIGHT_FRAC));
            r_out_z <= sat_to32(66'(r_acc[2] >>> WEIGHT_FRAC));
        end
    end

    assign o_empty = !r_out_valid;
    assign o_out_x = r_out_x;
    assign o_out_y = r_out_y;
    assign o_out_z = r_out_z;

endmodule

/* tb/sv/linear_blend_skinning_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_blend_skinning_tb
// Self-checking bench for the fixed-point linear blend skinning block.
// ----------------------------------------------------------------------------
// Joint matrices are loaded element by element, then vertices are sent as
// runs of weighted joint contributions. A scoreboard keeps its own copy of
// the matrix store and accumulators, computes each deformed position as the
// word closing a vertex is accepted, and compares it with the popped result.
// Both sides of the block stall at random, apart from one calm stretch.
// ----------------------------------------------------------------------------
module linear_blend_skinning_tb;
    import lbs_pkg::*;

    localparam bit CMD_LOAD    = 1'b0;
    localparam bit CMD_MIX     = 1'b1;
    localparam int RUN_WORDS   = 1450;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 64;
    localparam int REPORT_MAX  = 10;
    localparam int IDLE_PCT    = 13;

    typedef struct packed {
        logic               command;
        logic [5:0]         joint;
        logic [3:0]         element;
        logic signed [31:0] value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        weight;
        logic               last;
    } t_word;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_pos;

    class skin_scoreboard;
        logic signed [31:0] matrix [DEF_MAX_JOINTS * MAT_ELEMS];
        logic signed [63:0] acc [3];
        t_pos               pending [$];
        int                 mismatches;
        int                 results;

        function new();
            foreach (matrix[i]) matrix[i] = '0;
            foreach (acc[i]) acc[i] = '0;
            mismatches = 0;
            results    = 0;
        endfunction

        function logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [63:0] s;
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63])
                s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            return s;
        endfunction

        function logic signed [31:0] clamp32(logic signed [63:0] v);
            if (v > 64'sd2147483647)
                return 32'sh7fffffff;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return v[31:0];
        endfunction

        // one row of the affine transform, in Q16.16
        function logic signed [31:0] row_sum(int base, logic signed [63:0] x,
                                             logic signed [63:0] y, logic signed [63:0] z);
            logic signed [63:0] m0, m1, m2, m3, s;
            m0 = 64'(matrix[base]);
            m1 = 64'(matrix[base + 1]);
            m2 = 64'(matrix[base + 2]);
            m3 = 64'(matrix[base + 3]);
            s = m0 * x;
            s = sat_add(s, m1 * y);
            s = sat_add(s, m2 * z);
            s = sat_add(s, m3 <<< DEF_FRAC_BITS);
            return clamp32(s >>> DEF_FRAC_BITS);
        endfunction

        function void note_word(t_word w);
            int                 base;
            logic signed [63:0] px, py, pz, wt, rv;
            t_pos               res;
            if (w.command == CMD_LOAD) begin
                if (w.element < MAT_ELEMS && w.joint < DEF_MAX_JOINTS)
                    matrix[w.joint * MAT_ELEMS + w.element] = w.value;
                return;
            end
            if (w.joint < DEF_MAX_JOINTS) begin
                base = w.joint * MAT_ELEMS;
                px   = 64'(w.pos_x);
                py   = 64'(w.pos_y);
                pz   = 64'(w.pos_z);
                wt   = 64'(w.weight);
                for (int r = 0; r < 3; r++) begin
                    rv     = 64'(row_sum(base + 4 * r, px, py, pz));
                    acc[r] = sat_add(acc[r], rv * wt);
                end
            end
            if (w.last) begin
                res.x = clamp32(acc[0] >>> WEIGHT_FRAC);
                res.y = clamp32(acc[1] >>> WEIGHT_FRAC);
                res.z = clamp32(acc[2] >>> WEIGHT_FRAC);
                pending = {pending, res};
                foreach (acc[i]) acc[i] = '0;
            end
        endfunction

        function void report(string axis, logic [31:0] want, logic [31:0] got);
            if (mismatches < REPORT_MAX)
                $display("vertex %0d out_%s: expected %h, got %h", results, axis, want, got);
            mismatches++;
        endfunction

        function void check_result(t_pos got);
            t_pos want;
            results++;
            if (pending.size() == 0) begin
                if (mismatches < REPORT_MAX)
                    $display("vertex %0d: result popped with nothing pending", results);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x) report("x", want.x, got.x);
            if (got.y !== want.y) report("y", want.y, got.y);
            if (got.z !== want.z) report("z", want.z, got.z);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic               i_command;
    logic [5:0]         i_joint;
    logic [3:0]         i_element;
    logic signed [31:0] i_value;
    logic signed [31:0] i_pos_x;
    logic signed [31:0] i_pos_y;
    logic signed [31:0] i_pos_z;
    logic [15:0]        i_weight;
    logic               i_last;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [31:0] o_out_z;

    skin_scoreboard sb;
    logic [11:0]    elem_set [DEF_MAX_JOINTS];
    bit             calm = 1'b0;
    int             cycles = 0;
    int             words_sent = 0;
    int             n_loads = 0;
    int             n_ignored = 0;
    int             n_mix = 0;

    linear_blend_skinning u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_command (i_command),
        .i_joint   (i_joint),
        .i_element (i_element),
        .i_value   (i_value),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_pos_z   (i_pos_z),
        .i_weight  (i_weight),
        .i_last    (i_last),
        .empty     (empty),
        .pop       (pop),
        .o_out_x   (o_out_x),
        .o_out_y   (o_out_y),
        .o_out_z   (o_out_z)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_result('{x: o_out_x, y: o_out_y, z: o_out_z});
    end

    function automatic logic signed [31:0] pick_matrix_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh80000000;
            1:       return 32'sh7fffffff;
            2:       return '0;
            3, 4:    return $urandom_range(0, 262144) - 131072;
            5, 6, 7: return $urandom_range(0, 1048576) - 524288;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic signed [31:0] pick_position();
        case ($urandom_range(0, 9))
            0:       return 32'sh80000000;
            1:       return 32'sh7fffffff;
            2:       return '0;
            3, 4, 5: return $urandom_range(0, 33554432) - 16777216;
            6, 7:    return $urandom_range(0, 1048576) - 524288;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 9))
            0:       return 16'd32768;
            1:       return 16'd0;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // only joints with all twelve elements written may be used
    function automatic logic [5:0] pick_loaded_joint();
        logic [5:0] j;
        j = 6'($urandom_range(0, DEF_MAX_JOINTS - 1));
        while (elem_set[j] != 12'hfff)
            j = 6'($urandom_range(0, DEF_MAX_JOINTS - 1));
        return j;
    endfunction

    // starts and ends at a falling edge
    task automatic send_word(input t_word w);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push      = 1'b1;
        i_command = w.command;
        i_joint   = w.joint;
        i_element = w.element;
        i_value   = w.value;
        i_pos_x   = w.pos_x;
        i_pos_y   = w.pos_y;
        i_pos_z   = w.pos_z;
        i_weight  = w.weight;
        i_last    = w.last;
        do @(posedge i_clk); while (full);
        sb.note_word(w);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_elem(input logic [5:0] j, input logic [3:0] e, input logic [31:0] v);
        t_word w;
        w = '{command: CMD_LOAD, joint: j, element: e, value: v, pos_x: $urandom(),
              pos_y: $urandom(), pos_z: $urandom(), weight: 16'($urandom()),
              last: 1'($urandom())};
        send_word(w);
        n_loads++;
        if (e < MAT_ELEMS)
            elem_set[j][e] = 1'b1;
        else
            n_ignored++;
    endtask

    task automatic load_joint(input logic [5:0] j);
        for (int e = 0; e < MAT_ELEMS; e++)
            load_elem(j, 4'(e), pick_matrix_value());
    endtask

    task automatic mix_word(input logic [5:0] j, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [15:0] wt, input logic lst);
        t_word w;
        w = '{command: CMD_MIX, joint: j, element: 4'($urandom()), value: $urandom(),
              pos_x: x, pos_y: y, pos_z: z, weight: wt, last: lst};
        send_word(w);
        n_mix++;
    endtask

    task automatic directed_words();
        logic [31:0] extreme_mat [MAT_ELEMS];
        extreme_mat = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                        32'h00010000, 32'h00000000, 32'h00000000, 32'h7fffffff,
                        32'h00000000, 32'hffff0000, 32'h00010000, 32'hffffffff};
        for (int e = 0; e < MAT_ELEMS; e++)
            load_elem(6'd63, 4'(e), extreme_mat[e]);
        // elements past the matrix must not spill into the next joint
        load_elem(6'd62, 4'd12, 32'h12345678);
        load_elem(6'd62, 4'd15, 32'hffffffff);
        mix_word(6'd63, 32'h80000000, 32'h80000000, 32'h80000000, 16'd32768, 1'b1);
        mix_word(6'd63, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'hffff, 1'b1);
        mix_word(6'd63, 32'h0, 32'h0, 32'h0, 16'd0, 1'b1);
        mix_word(6'd63, 32'h0, 32'h0, 32'h0, 16'd32768, 1'b1);
        // three maximal contributions into one vertex
        for (int k = 0; k < 3; k++)
            mix_word(6'd63, 32'h7fffffff, 32'h80000000, 32'h00010000, 16'hffff, k == 2);
        mix_word(6'd63, 32'hfffe8000, 32'h00024000, 32'hfffd0000, 16'd12345, 1'b1);
    endtask

    task automatic random_words();
        int pick;
        int n;
        load_joint(6'd0);
        while (words_sent < RUN_WORDS) begin
            calm = (words_sent >= 500 && words_sent < 800);
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                load_joint(6'($urandom_range(0, DEF_MAX_JOINTS - 1)));
            end else if (pick < 16) begin
                load_elem(6'($urandom_range(0, DEF_MAX_JOINTS - 1)),
                          4'($urandom_range(0, 11)), pick_matrix_value());
            end else if (pick < 20) begin
                load_elem(6'($urandom_range(0, DEF_MAX_JOINTS - 1)),
                          4'($urandom_range(12, 15)), $urandom());
            end else begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                    mix_word(pick_loaded_joint(), pick_position(), pick_position(),
                             pick_position(), pick_weight(), k == n - 1);
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n   = 1'b0;
        push      = 1'b0;
        i_command = CMD_LOAD;
        i_joint   = '0;
        i_element = '0;
        i_value   = '0;
        i_pos_x   = '0;
        i_pos_y   = '0;
        i_pos_z   = '0;
        i_weight  = '0;
        i_last    = 1'b0;
        foreach (elem_set[j]) elem_set[j] = '0;
        sb = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_words();
        random_words();
        push = 1'b0;

        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("%0d words: %0d matrix loads (%0d outside the matrix), %0d joint contributions",
                 words_sent, n_loads, n_ignored, n_mix);
        $display("%0d deformed vertices compared over %0d cycles, %0d mismatches",
                 sb.results, cycles, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
sv/lbs_pkg.sv
sv/lbs_ram.sv
sv/lbs_front.sv
sv/lbs_back.sv
sv/linear_blend_skinning.sv
tb/sv/linear_blend_skinning_tb.sv
